/* rtl/hpt_pkg.sv */
// ----------------------------------------------------------------------------
// hpt_pkg: shared types and constants of the hashed position table
// Item and table-row layouts, hash constants, op codes.
// ----------------------------------------------------------------------------
`default_nettype none

package hpt_pkg;

	localparam int INDEX_BITS_DEF = 16;
	localparam int QUEUE_DEPTH    = 2;

	localparam logic [31:0] HASH_BASIS  = 32'h811C_9DC5;
	localparam logic [31:0] HASH_PRIME  = 32'h0100_0193;
	localparam logic [6:0]  DEPTH_SLACK = 7'd2;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_STORE  = 1'b1;

	typedef struct packed {
		logic              op;
		logic [63:0]       white;
		logic [63:0]       black;
		logic              side;
		logic signed [7:0] score;
		logic [5:0]        move;
		logic [5:0]        depth;
	} item_t;

	typedef struct packed {
		logic              valid;
		logic [63:0]       white;
		logic [63:0]       black;
		logic              side;
		logic signed [7:0] score;
		logic [5:0]        move;
		logic [5:0]        depth;
	} row_t;

	localparam int ITEM_W     = $bits(item_t);
	localparam int ROW_W      = $bits(row_t);
	localparam int IN_TDATA_W = 152;
	localparam int OUT_TDATA_W = 24;

	// one FNV-1a step: xor in a 32-bit word, multiply modulo 2^32
	function automatic logic [31:0] hash_mix(logic [31:0] h, logic [31:0] w);
		return (h ^ w) * HASH_PRIME;
	endfunction

endpackage

`default_nettype wire

/* rtl/hpt_ram.sv */
// ----------------------------------------------------------------------------
// hpt_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/hpt_front.sv */
// ----------------------------------------------------------------------------
// hpt_front: hash pipeline
// Four stages, one FNV-1a multiply each; the whole pipe stalls as one.
// ----------------------------------------------------------------------------
`default_nettype none

module hpt_front #(
	parameter int INDEX_BITS = hpt_pkg::INDEX_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire hpt_pkg::item_t        in_item,
	output      logic                  in_ready,
	input  wire logic                  hold,      // table clear in progress
	output      logic                  out_valid,
	output      hpt_pkg::item_t        out_item,
	output      logic [INDEX_BITS-1:0] out_index,
	input  wire logic                  out_ready
);

	import hpt_pkg::*;

	logic        v_s1, v_s2, v_s3, v_s4;
	item_t       item_s1, item_s2, item_s3, item_s4;
	logic [31:0] hash_s1, hash_s2, hash_s3, hash_s4;
	logic [63:0] in_both, both_s1;
	logic        adv;

	assign adv      = !(v_s4 && !out_ready);
	assign in_ready = adv && !hold;
	assign in_both  = in_item.white | in_item.black;
	assign both_s1  = item_s1.white | item_s1.black;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid && in_ready;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= in_item;
			hash_s1 <= hash_mix(HASH_BASIS, in_both[31:0]);
			item_s2 <= item_s1;
			hash_s2 <= hash_mix(hash_s1, both_s1[63:32]);
			item_s3 <= item_s2;
			hash_s3 <= hash_mix(hash_s2, item_s2.black[31:0]);
			item_s4 <= item_s3;
			hash_s4 <= hash_mix(hash_s3, item_s3.black[63:32]);
		end
	end

	assign out_valid = v_s4;
	assign out_item  = item_s4;
	assign out_index = hash_s4[INDEX_BITS-1:0];

endmodule

`default_nettype wire

/* rtl/hpt_fifo.sv */
// ----------------------------------------------------------------------------
// hpt_fifo: short register queue
// Decouples the hash pipe from the table engine.
// ----------------------------------------------------------------------------
`default_nettype none

module hpt_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = hpt_pkg::QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output      logic             not_full,
	input  wire logic             pop,
	output      logic [WIDTH-1:0] pop_data,
	output      logic             not_empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign not_full  = cnt_q != CNT_FULL;
	assign not_empty = cnt_q != '0;
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

/* rtl/hpt_back.sv */
// ----------------------------------------------------------------------------
// hpt_back: table engine
// Clears the table after reset, then per item reads one slot and
// conditionally writes it back; owns the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module hpt_back #(
	parameter int INDEX_BITS = hpt_pkg::INDEX_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	output      logic                        clearing,
	input  wire logic                        q_valid,
	input  wire hpt_pkg::item_t              q_item,
	input  wire logic [INDEX_BITS-1:0]       q_index,
	output      logic                        q_pop,
	output      logic                        res_valid,
	output      logic [hpt_pkg::OUT_TDATA_W-1:0] res_data,
	input  wire logic                        res_ready
);

	import hpt_pkg::*;

	localparam logic [1:0] ST_CLEAR  = 2'd0;
	localparam logic [1:0] ST_FETCH  = 2'd1;
	localparam logic [1:0] ST_DECIDE = 2'd2;
	localparam logic [INDEX_BITS-1:0] IDX_LAST = '1;

	logic [1:0]            st_q;
	logic [INDEX_BITS-1:0] clr_idx_q;
	item_t                 cur_q;
	logic [INDEX_BITS-1:0] cur_idx_q;
	logic                  res_valid_q;
	logic [OUT_TDATA_W-1:0] res_data_q;

	logic                  ram_we;
	logic [INDEX_BITS-1:0] ram_waddr;
	row_t                  ram_wrow;
	logic [ROW_W-1:0]      ram_rdata;
	row_t                  slot;
	logic                  out_free, finish, take, hit, written;
	logic [OUT_TDATA_W-1:0] res_next;

	hpt_ram #(
		.WIDTH(ROW_W),
		.DEPTH(2 ** INDEX_BITS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wrow),
		.re   (q_pop),
		.raddr(q_index),
		.rdata(ram_rdata)
	);

	assign slot     = row_t'(ram_rdata);
	assign clearing = st_q == ST_CLEAR;
	assign q_pop    = (st_q == ST_FETCH) && q_valid;
	assign out_free = !res_valid_q || res_ready;
	assign finish   = (st_q == ST_DECIDE) && out_free;

	always_comb begin
		take    = !slot.valid || ({1'b0, cur_q.depth} + DEPTH_SLACK >= {1'b0, slot.depth});
		written = (cur_q.op == OP_STORE) && take;
		hit     = (cur_q.op == OP_LOOKUP) && slot.valid && (slot.white == cur_q.white)
		          && (slot.black == cur_q.black) && (slot.side == cur_q.side);
		res_next = '0;
		res_next[0] = hit;
		res_next[1] = written;
		if (hit) begin
			res_next[9:2]   = slot.score;
			res_next[15:10] = slot.move;
			res_next[21:16] = slot.depth;
		end

		ram_we    = 1'b0;
		ram_waddr = cur_idx_q;
		ram_wrow  = '0;
		if (clearing) begin
			ram_we    = 1'b1;
			ram_waddr = clr_idx_q;
		end else if (finish && written) begin
			ram_we   = 1'b1;
			ram_wrow = '{valid: 1'b1, white: cur_q.white, black: cur_q.black,
			             side: cur_q.side, score: cur_q.score, move: cur_q.move,
			             depth: cur_q.depth};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_CLEAR;
			clr_idx_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			unique case (st_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == IDX_LAST) begin
						st_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					if (q_valid) begin
						st_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (out_free) begin
						st_q <= ST_FETCH;
					end
				end
				default: begin
					st_q <= ST_CLEAR;
				end
			endcase
			if (finish) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q     <= q_item;
			cur_idx_q <= q_index;
		end
		if (finish) begin
			res_data_q <= res_next;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_data_q;

endmodule

`default_nettype wire

/* rtl/hashed_position_table_core.sv */
// ----------------------------------------------------------------------------
// hashed_position_table_core: direct-mapped position table
// Lookup/store of board positions keyed by two occupancy masks and side.
// ----------------------------------------------------------------------------
// After reset the block sweeps the table to empty, one slot per cycle, over
// all 2**INDEX_BITS slots (65536 at the default); s_tready stays low meanwhile.
// Each transfer on the slave side is a lookup (s_tuser = 0) or a store
// (s_tuser = 1) and yields exactly one transfer on the master side, in order.
// The hash (FNV-1a over the union mask, then the black mask, 32 bits a step)
// runs in a 4-stage pipe. m_tvalid is reached through the four hash stages,
// the queue, the slot read in the table RAM and the result register.
// The table engine takes one item at a time: one slot read, then the compare
// and optional write on the same single-write RAM, and it fetches no new
// item until the result register is free. A 2-entry queue sits between the
// hash pipe and the table engine so each side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module hashed_position_table_core #(
	parameter int INDEX_BITS = hpt_pkg::INDEX_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// slave side: item in
	input  wire logic                             s_tvalid,
	output      logic                             s_tready,
	// tdata, low to high: white_mask[63:0], black_mask[127:64], side_to_move[128],
	// new_score[136:129], new_move[142:137], new_depth[148:143], zero pad
	input  wire logic [hpt_pkg::IN_TDATA_W-1:0]   s_tdata,
	// tuser: op (0 lookup, 1 store)
	input  wire logic                             s_tuser,
	// master side: result out
	output      logic                             m_tvalid,
	input  wire logic                             m_tready,
	// tdata, low to high: hit[0], written[1], found_score[9:2],
	// found_move[15:10], found_depth[21:16], zero pad
	output      logic [hpt_pkg::OUT_TDATA_W-1:0]  m_tdata
);

	import hpt_pkg::*;

	localparam int QW = INDEX_BITS + ITEM_W;

	item_t                 in_item;
	logic                  clearing;

	// hash pipe -> queue
	logic                  f_valid;
	item_t                 f_item;
	logic [INDEX_BITS-1:0] f_index;
	logic                  q_not_full;

	// queue -> table engine
	logic [QW-1:0]         q_data;
	logic                  q_not_empty;
	logic                  q_pop;
	item_t                 q_item;
	logic [INDEX_BITS-1:0] q_index;

	// unpack the slave-side transfer
	assign in_item = '{op: s_tuser, white: s_tdata[63:0], black: s_tdata[127:64],
	                   side: s_tdata[128], score: s_tdata[136:129],
	                   move: s_tdata[142:137], depth: s_tdata[148:143]};

	hpt_front #(
		.INDEX_BITS(INDEX_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_item  (in_item),
		.in_ready (s_tready),
		.hold     (clearing),
		.out_valid(f_valid),
		.out_item (f_item),
		.out_index(f_index),
		.out_ready(q_not_full)
	);

	hpt_fifo #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (f_valid && q_not_full),
		.push_data({f_index, f_item}),
		.not_full (q_not_full),
		.pop      (q_pop),
		.pop_data (q_data),
		.not_empty(q_not_empty)
	);

	assign q_item  = item_t'(q_data[ITEM_W-1:0]);
	assign q_index = q_data[QW-1:ITEM_W];

	// table engine also holds the master-side output register
	hpt_back #(
		.INDEX_BITS(INDEX_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.clearing (clearing),
		.q_valid  (q_not_empty),
		.q_item   (q_item),
		.q_index  (q_index),
		.q_pop    (q_pop),
		.res_valid(m_tvalid),
		.res_data (m_tdata),
		.res_ready(m_tready)
	);

endmodule

`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for hashed_position_table_core
// Streams lookups and stores through the table with random gaps on both
// sides. A shadow table predicts each outcome when its transfer is accepted,
// and the bench compares every returned field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
	import hpt_pkg::*;

	localparam int SLOT_COUNT   = 1 << INDEX_BITS_DEF;
	localparam int RANDOM_ITEMS = 800;
	localparam int POOL_LIMIT   = 48;

	// match key of a position
	typedef struct packed {
		logic [63:0] white;
		logic [63:0] black;
		logic        side;
	} key_t;

	// item waiting in the driver, with the idle cycles that precede it
	typedef struct {
		item_t       body;
		int unsigned gap;
	} pending_t;

	// what the table should answer for one item
	typedef struct packed {
		logic              hit;
		logic              written;
		logic signed [7:0] score;
		logic [5:0]        move;
		logic [5:0]        depth;
	} outcome_t;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata  = '0;
	logic                   s_tuser  = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	logic hold_off = 1'b0;

	pending_t    item_queue[$];
	key_t        key_pool[$];
	outcome_t    outcome_queue[$];
	row_t        shadow_table[SLOT_COUNT];
	item_t       held_item;
	pending_t    next_pending;
	outcome_t    want_outcome;
	logic        offer_next;
	int unsigned items_total   = 0;
	int unsigned items_sent    = 0;
	int unsigned results_seen  = 0;
	int unsigned error_count   = 0;
	int unsigned send_wait     = 0;
	int unsigned recv_wait     = 0;

	hashed_position_table_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// FNV-1a over union low/high, then black low/high; low index bits pick the slot
	function automatic logic [INDEX_BITS_DEF-1:0] slot_of(logic [63:0] white,
			logic [63:0] black);
		logic [63:0] both;
		logic [31:0] h;
		logic [31:0] words[4];
		both     = white | black;
		words[0] = both[31:0];
		words[1] = both[63:32];
		words[2] = black[31:0];
		words[3] = black[63:32];
		h        = HASH_BASIS;
		for (int i = 0; i < 4; i++)
			h = (h ^ words[i]) * HASH_PRIME;
		return h[INDEX_BITS_DEF-1:0];
	endfunction

	// applies one item to the shadow table and returns the expected answer
	function automatic outcome_t probe_table(item_t it);
		logic [INDEX_BITS_DEF-1:0] idx;
		row_t                      row;
		outcome_t                  res;
		idx = slot_of(it.white, it.black);
		row = shadow_table[idx];
		res = '0;
		if (it.op == OP_STORE) begin
			// depth plus slack is compared without wrap, so it may reach 65
			if (!row.valid || int'(it.depth) + int'(DEPTH_SLACK) >= int'(row.depth)) begin
				shadow_table[idx] = '{valid: 1'b1, white: it.white, black: it.black,
					side: it.side, score: it.score, move: it.move, depth: it.depth};
				res.written = 1'b1;
			end
		end else if (row.valid && row.white == it.white && row.black == it.black &&
				row.side == it.side) begin
			res.hit   = 1'b1;
			res.score = row.score;
			res.move  = row.move;
			res.depth = row.depth;
		end
		return res;
	endfunction

	task automatic add_item(logic op, key_t k, logic signed [7:0] score, logic [5:0] move,
			logic [5:0] depth);
		pending_t p;
		p.body = '{op: op, white: k.white, black: k.black, side: k.side, score: score,
			move: move, depth: depth};
		// every fourth block of 40 items runs back to back
		p.gap  = ((item_queue.size() / 40) % 4 == 1) ? 0 : $urandom_range(0, 19);
		item_queue.push_back(p);
	endtask

	task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
		$display("result %0d: %s expected %0h, got %0h", results_seen, field, want, got);
		error_count++;
	endtask

	// driver: offers queued items, predicts each one on its accepted transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			send_wait = 0;
		end else begin
			offer_next = s_tvalid;
			if (s_tvalid && s_tready) begin
				outcome_queue.push_back(probe_table(held_item));
				items_sent++;
				offer_next = 1'b0;
				if (item_queue.size() != 0)
					send_wait = item_queue[0].gap;
			end
			if (!offer_next && item_queue.size() != 0) begin
				if (send_wait != 0) begin
					send_wait--;
				end else begin
					next_pending = item_queue.pop_front();
					held_item    = next_pending.body;
					s_tdata <= {3'b000, held_item.depth, held_item.move, held_item.score,
						held_item.side, held_item.black, held_item.white};
					s_tuser <= held_item.op;
					offer_next = 1'b1;
				end
			end
			s_tvalid <= offer_next;
		end
	end

	// monitor: checks each result transfer, then draws the next stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_wait = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (outcome_queue.size() == 0) begin
					report_mismatch("result with nothing pending", 0, 32'(m_tdata));
				end else begin
					want_outcome = outcome_queue.pop_front();
					if (m_tdata[0] !== want_outcome.hit)
						report_mismatch("hit", 32'(want_outcome.hit), 32'(m_tdata[0]));
					if (m_tdata[1] !== want_outcome.written)
						report_mismatch("written", 32'(want_outcome.written),
							32'(m_tdata[1]));
					if (m_tdata[9:2] !== want_outcome.score)
						report_mismatch("found_score", 32'(want_outcome.score),
							32'(m_tdata[9:2]));
					if (m_tdata[15:10] !== want_outcome.move)
						report_mismatch("found_move", 32'(want_outcome.move),
							32'(m_tdata[15:10]));
					if (m_tdata[21:16] !== want_outcome.depth)
						report_mismatch("found_depth", 32'(want_outcome.depth),
							32'(m_tdata[21:16]));
				end
				results_seen++;
				recv_wait = ((results_seen / 50) % 3 == 1) ? 0 : $urandom_range(0, 19);
			end else if (recv_wait != 0) begin
				recv_wait--;
			end
			m_tready <= (recv_wait == 0) && !hold_off;
		end
	end

	// long receiver hold-off while the sender keeps going: fills the pipe
	initial begin
		while (items_sent < 150)
			@(posedge clk);
		hold_off <= 1'b1;
		repeat (400) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#5_000_000;
		$display("hashed_position_table_core: mismatch");
		$finish;
	end

	initial begin
		key_t        zero_k;
		key_t        ones_k;
		key_t        alias_k;
		key_t        rand_k;
		key_t        k;
		logic        op;
		int unsigned pick;

		foreach (shadow_table[i])
			shadow_table[i] = '0;

		zero_k  = '0;
		ones_k  = '{white: '1, black: '1, side: 1'b1};
		// same union and black mask as ones_k, so same slot but another key
		alias_k = '{white: ~64'h00FF_00FF_00FF_00FF, black: '1, side: 1'b0};
		rand_k  = '{white: {$urandom, $urandom}, black: {$urandom, $urandom}, side: 1'b0};

		// directed: empty slot, extremes, depth rule edges, side and alias misses
		add_item(OP_LOOKUP, zero_k, 0, 0, 0);
		add_item(OP_STORE,  zero_k, 0, 0, 0);
		add_item(OP_LOOKUP, zero_k, 0, 0, 0);
		add_item(OP_LOOKUP, '{white: '0, black: '0, side: 1'b1}, 0, 0, 0);
		add_item(OP_STORE,  ones_k, -64, 63, 63);
		add_item(OP_LOOKUP, ones_k, 0, 0, 0);
		add_item(OP_STORE,  ones_k, 5, 1, 60);      // 62 < 63: refused
		add_item(OP_LOOKUP, ones_k, 0, 0, 0);
		add_item(OP_STORE,  ones_k, 64, 17, 61);    // 63 >= 63: replaces
		add_item(OP_LOOKUP, ones_k, 0, 0, 0);
		add_item(OP_STORE,  alias_k, -1, 42, 59);   // other key, same slot, 61 >= 61
		add_item(OP_LOOKUP, ones_k, 0, 0, 0);
		add_item(OP_LOOKUP, alias_k, 0, 0, 0);
		add_item(OP_STORE,  alias_k, 3, 3, 0);      // 2 < 59: refused
		add_item(OP_LOOKUP, alias_k, 0, 0, 0);
		add_item(OP_STORE,  rand_k, 1, 31, 63);
		add_item(OP_STORE,  rand_k, -7, 9, 62);     // same key follows depth rule
		add_item(OP_LOOKUP, rand_k, 0, 0, 0);
		add_item(OP_STORE,  rand_k, 2, 2, 0);       // refused
		add_item(OP_STORE,  rand_k, 63, 63, 63);    // 65 >= 62: no wrap in the sum
		add_item(OP_LOOKUP, rand_k, 0, 0, 0);
		add_item(OP_LOOKUP, '{white: rand_k.white, black: rand_k.black, side: 1'b1},
			0, 0, 0);

		key_pool.push_back(zero_k);
		key_pool.push_back(ones_k);
		key_pool.push_back(alias_k);
		key_pool.push_back(rand_k);

		// random: mostly keys already seen so lookups hit and stores contend
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			op   = $urandom_range(0, 1) ? OP_STORE : OP_LOOKUP;
			pick = $urandom_range(0, 9);
			k    = key_pool[$urandom_range(0, key_pool.size() - 1)];
			if (pick < 3) begin
				k.white = {$urandom, $urandom};
				k.black = {$urandom, $urandom};
				if (pick == 0)
					k.black &= ~k.white;
				k.side = 1'($urandom_range(0, 1));
				if (op == OP_STORE) begin
					if (key_pool.size() < POOL_LIMIT)
						key_pool.push_back(k);
					else
						key_pool[$urandom_range(0, POOL_LIMIT - 1)] = k;
				end
			end else if (pick == 3) begin
				// white bits under black do not move the hash: slot collision
				k.white ^= k.black & {$urandom, $urandom};
			end else if (pick == 4) begin
				k.side = ~k.side;
			end
			add_item(op, k, 8'(int'($urandom_range(0, 128)) - 64),
				6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
		end
		items_total = item_queue.size();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// table clear sweep runs first; s_tready holds the driver off meanwhile
		while (items_sent != items_total || outcome_queue.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);

		if (error_count == 0)
			$display("hashed_position_table_core: match");
		else
			$display("hashed_position_table_core: mismatch");
		$finish;
	end

endmodule

/* sim.f */
rtl/hpt_pkg.sv
rtl/hpt_ram.sv
rtl/hpt_front.sv
rtl/hpt_fifo.sv
rtl/hpt_back.sv
rtl/hashed_position_table_core.sv
sim/tb.sv
